### rtl/sdp_pkg.sv
// ---------------------------------------------------------------------------
// sdp_pkg
// Types, codes and per-byte parsing functions for the SSE data event parser.
// ---------------------------------------------------------------------------
package sdp_pkg;

    // Default depth of the work queue between the front and back ends
    localparam int SDP_QUEUE_DEPTH = 4;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters of interest
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Field name that contributes to the payload
    localparam logic [7:0] FIELD_WORD [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

    // Name match count: number of field name chars matched, or mismatch
    localparam logic [2:0] NM_FULL = 3'd4;
    localparam logic [2:0] NM_BAD  = 3'd5;

    // Position within the current line
    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_NAME      = 3'd1,
        PH_VAL_FIRST = 3'd2,
        PH_VAL       = 3'd3,
        PH_SKIP      = 3'd4
    } phase_t;

    // Line parser state (CR hold kept separately in the front end)
    typedef struct packed {
        phase_t     phase;
        logic [2:0] nm;
        logic       hd;
    } pst_t;

    // One parse step: new state plus at most one result
    typedef struct packed {
        pst_t       st;
        logic       emit;
        logic       kind;
        logic [7:0] dat;
    } step_t;

    // Queue entry: one or two results caused by one input word
    typedef struct packed {
        logic       two;
        logic       kind0;
        logic [7:0] dat0;
        logic       kind1;
        logic [7:0] dat1;
    } work_t;

    // Queue status: full drives in_ready, empty is seen by the back end
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Step that changes nothing and emits nothing
    function automatic step_t no_step(pst_t s);
        step_t r;
        r.st   = s;
        r.emit = 1'b0;
        r.kind = KIND_BYTE;
        r.dat  = 8'h00;
        return r;
    endfunction

    // Feed one ordinary line byte
    function automatic step_t line_byte(pst_t s, logic [7:0] b);
        step_t      r;
        logic [2:0] nm;
        r  = no_step(s);
        nm = (s.phase == PH_START) ? 3'd0 : s.nm;
        unique case (s.phase) inside
            PH_START, PH_NAME:
            begin
                if (s.phase == PH_START && b == CH_COLON)
                begin
                    // comment line
                    r.st.phase = PH_SKIP;
                end
                else if (b == CH_COLON)
                begin
                    r.st.nm = nm;
                    if (nm == NM_FULL)
                    begin
                        // data field: separator before all but the first line
                        r.emit     = s.hd;
                        r.dat      = s.hd ? CH_LF : 8'h00;
                        r.st.hd    = 1'b1;
                        r.st.phase = PH_VAL_FIRST;
                    end
                    else
                    begin
                        r.st.phase = PH_SKIP;
                    end
                end
                else
                begin
                    r.st.phase = PH_NAME;
                    if (nm < NM_FULL && b == FIELD_WORD[nm[1:0]])
                        r.st.nm = nm + 3'd1;
                    else
                        r.st.nm = NM_BAD;
                end
            end
            PH_VAL_FIRST:
            begin
                r.st.phase = PH_VAL;
                r.emit     = (b != CH_SPACE);
                r.dat      = b;
            end
            PH_VAL:
            begin
                r.emit = 1'b1;
                r.dat  = b;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // End of the current line
    function automatic step_t line_end(pst_t s);
        step_t r;
        r = no_step(s);
        if (s.phase == PH_START)
        begin
            // empty line closes the event
            r.emit  = s.hd;
            r.kind  = KIND_END;
            r.st.hd = 1'b0;
        end
        else if (s.phase == PH_NAME && s.nm == NM_FULL)
        begin
            // bare "data" line adds an empty value
            r.emit  = s.hd;
            r.dat   = s.hd ? CH_LF : 8'h00;
            r.st.hd = 1'b1;
        end
        r.st.phase = PH_START;
        r.st.nm    = 3'd0;
        return r;
    endfunction

    // Close the event if it carries data
    function automatic step_t close_ev(pst_t s);
        step_t r;
        r       = no_step(s);
        r.emit  = s.hd;
        r.kind  = KIND_END;
        r.st.hd = 1'b0;
        return r;
    endfunction

endpackage

### rtl/sdp_front.sv
// ---------------------------------------------------------------------------
// sdp_front
// Accepts input words, runs the line parser and posts results to the queue.
// ---------------------------------------------------------------------------
module sdp_front
    import sdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       op,
    input  logic [7:0] in_byte,
    output logic       push,
    output work_t      push_entry
);

    pst_t  st_reg;
    pst_t  st_next;
    logic  cr_reg;
    logic  cr_next;
    logic  accept;
    step_t sa;
    step_t sb;

    assign accept = in_valid && in_ready;

    // Two parse steps per word: released CR (or line end), then the word
    always_comb
    begin
        cr_next = 1'b0;
        if (op == OP_END)
        begin
            sa = (st_reg.phase != PH_START) ? line_end(st_reg) : no_step(st_reg);
            sb = close_ev(sa.st);
        end
        else if (in_byte == CH_LF)
        begin
            sa = line_end(st_reg);
            sb = no_step(sa.st);
        end
        else
        begin
            sa = cr_reg ? line_byte(st_reg, CH_CR) : no_step(st_reg);
            if (in_byte == CH_CR)
            begin
                sb      = no_step(sa.st);
                cr_next = 1'b1;
            end
            else
            begin
                sb = line_byte(sa.st, in_byte);
            end
        end
        st_next = sb.st;
        if (op == OP_END)
        begin
            st_next.phase = PH_START;
            st_next.nm    = 3'd0;
        end
    end

    // Pack the results into one queue entry
    always_comb
    begin
        push_entry.two   = sa.emit && sb.emit;
        push_entry.kind0 = sa.emit ? sa.kind : sb.kind;
        push_entry.dat0  = sa.emit ? sa.dat : sb.dat;
        push_entry.kind1 = sb.kind;
        push_entry.dat1  = sb.dat;
    end

    assign push = accept && (sa.emit || sb.emit);

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_START, nm: 3'd0, hd: 1'b0};
            cr_reg <= 1'b0;
        end
        else if (accept)
        begin
            st_reg <= st_next;
            cr_reg <= cr_next;
        end
    end

endmodule

### rtl/sdp_fifo.sv
// ---------------------------------------------------------------------------
// sdp_fifo
// Short work queue between the parser front end and the output back end.
// ---------------------------------------------------------------------------
module sdp_fifo
    import sdp_pkg::*;
#(
    parameter int DEPTH = SDP_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  work_t  push_entry,
    input  logic   pop,
    output work_t  pop_entry,
    output qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // No write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) stat.full |-> !push)
        else $error("sdp_fifo: push while full");

    // No read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) stat.empty |-> !pop)
        else $error("sdp_fifo: pop while empty");

    // Count rises on a push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("sdp_fifo: count did not rise on push");

endmodule

### rtl/sdp_back.sv
// ---------------------------------------------------------------------------
// sdp_back
// Takes queue entries and delivers their results through an output register.
// ---------------------------------------------------------------------------
module sdp_back
    import sdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qstat_t     stat,
    input  work_t      pop_entry,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic       valid_reg;
    logic       valid_next;
    logic       kind_reg;
    logic       kind_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       sec_reg;
    logic       sec_next;
    logic       sec_kind_reg;
    logic       sec_kind_next;
    logic [7:0] sec_byte_reg;
    logic [7:0] sec_byte_next;
    logic       load;

    assign load = !valid_reg || out_ready;

    // Output register loads the pending second result first, then the queue
    always_comb
    begin
        valid_next    = valid_reg;
        kind_next     = kind_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        sec_next      = sec_reg;
        sec_kind_next = sec_kind_reg;
        sec_byte_next = sec_byte_reg;
        pop           = 1'b0;
        if (load)
        begin
            if (sec_reg)
            begin
                valid_next = 1'b1;
                kind_next  = sec_kind_reg;
                byte_next  = sec_byte_reg;
                last_next  = 1'b1;
                sec_next   = 1'b0;
            end
            else if (!stat.empty)
            begin
                pop           = 1'b1;
                valid_next    = 1'b1;
                kind_next     = pop_entry.kind0;
                byte_next     = pop_entry.dat0;
                last_next     = !pop_entry.two;
                sec_next      = pop_entry.two;
                sec_kind_next = pop_entry.kind1;
                sec_byte_next = pop_entry.dat1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sec_reg   <= sec_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        sec_kind_reg <= sec_kind_next;
        sec_byte_reg <= sec_byte_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign run_last  = last_reg;

endmodule

### rtl/sse_data_event_parser.sv
// ---------------------------------------------------------------------------
// sse_data_event_parser
// Server-sent events parser: streams out the payload of "data" fields.
// ---------------------------------------------------------------------------
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  input   | in_valid, in_ready, op, in_byte    | in
//  output  | out_valid, out_ready, out_kind,    | out
//          | out_byte, run_last                 |
//
//  One input word is taken per cycle while the work queue has room.
//  Results leave at one per cycle from the output register while out_ready is
//  high; a word that gives two results delivers the second after the first.
//  An accepted word is written to the queue, then moved to the output register.
//  Reset (rst_n low) returns the parser to line start and empties the queue.
//  A stalled output fills the queue, after which in_ready drops.
// ---------------------------------------------------------------------------
module sse_data_event_parser
    import sdp_pkg::*;
#(
    parameter int QUEUE_DEPTH = SDP_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic       run_last
);

    logic   push;
    logic   pop;
    work_t  push_entry;
    work_t  pop_entry;
    qstat_t stat;

    assign in_ready = !stat.full;

    // Parser front end
    sdp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .in_byte    (in_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    // Work queue
    sdp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (stat)
    );

    // Output back end
    sdp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule
